/* rtl/core/nccr_pkg.sv */
// ----------------------------------------------------------------------------
// Newton cubic root classifier package
// Shared types, constants and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nccr_pkg;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    // sqrt(3)/2 in Q2.30, rounded to nearest.
    localparam logic [65:0] SQRT3_HALF_Q30 = 66'd929887697;

    localparam logic [0:0] CFG_TOLERANCE = 1'b0;
    localparam logic [0:0] CFG_MAX_ITER  = 1'b1;

    typedef enum logic [2:0] {
        CLS_ROOT_ONE = 3'd0,
        CLS_UPPER    = 3'd1,
        CLS_LOWER    = 3'd2,
        CLS_ORIGIN   = 3'd3,
        CLS_NO_CONV  = 3'd4
    } t_root_class;

    // Sign and magnitude of one exact product.
    typedef struct packed {
        logic        neg;
        logic [62:0] mag;
    } t_prod;

    // Status of the shared divider.
    typedef struct packed {
        logic        done;
        logic        sat;
        logic [30:0] q;
    } t_div_res;

    function automatic logic signed [65:0] ext32(input logic signed [31:0] x);
        ext32 = {{34{x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > ext32(SAT_MAX)) begin
            sat32 = SAT_MAX;
        end else if (v < ext32(SAT_MIN)) begin
            sat32 = SAT_MIN;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/newton_cubic_root_classifier_core.sv */
// ----------------------------------------------------------------------------
// Newton cubic root classifier core
// Iterates Newton's method on z^3-1 and reports which cube root of one it reaches.
// ----------------------------------------------------------------------------
// An item is one Q(31-FRAC_BITS).FRAC_BITS complex start point; the result is
// its root class and the number of Newton steps taken. The block handles one
// item at a time. A start of zero goes straight to the result. Otherwise
// each Newton step runs through the single shared 32x32 multiplier and
// makes two passes through the shared divider, for the real and the
// imaginary quotient. A final convergence test and root match end the item.
`default_nettype none

module newton_cubic_root_classifier_core #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire logic signed [31:0] i_start_real,
    input  wire logic signed [31:0] i_start_imag,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      logic [2:0]         o_root_class,
    output      logic [7:0]         o_steps_taken,
    input  wire logic               i_cfg_valid,
    output      logic               o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [24:0]        i_cfg_data
);

    localparam logic signed [65:0] ONE  = 66'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] S3 =
        $signed((((nccr_pkg::SQRT3_HALF_Q30 * 66'd2) >> (30 - FRAC_BITS)) + 66'd1) >> 1);

    typedef enum logic [4:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
        S_C0, S_C1, S_C2, S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6,
        S_V0, S_V1, S_DONE
    } t_state;

    t_state              r_state;
    logic [24:0]         r_tol;
    logic [7:0]          r_max;
    logic [49:0]         r_tol2;
    logic signed [31:0]  r_zr, r_zi, r_z2r, r_z2i, r_wr, r_wi, r_dr, r_di, r_t;
    logic [63:0]         r_acc;
    logic [63:0]         r_den;
    logic signed [64:0]  r_nacc, r_nr, r_ni;
    logic [1:0]          r_k;
    logic [7:0]          r_steps;
    logic [2:0]          r_cls;
    logic                r_out_valid;
    logic [2:0]          r_out_class;
    logic [7:0]          r_out_steps;

    logic signed [31:0]  op_a, op_b;
    nccr_pkg::t_prod     prod;
    nccr_pkg::t_div_res  div;
    logic [62:0]         fm_sh;
    logic signed [31:0]  fm;
    logic signed [64:0]  ps;
    logic [64:0]         sumsq;
    logic signed [65:0]  root_r, root_i;
    logic signed [31:0]  dx, dy;
    logic                div_start;
    logic signed [64:0]  div_src;
    logic [63:0]         div_num;
    logic [31:0]         q_mag;
    logic signed [65:0]  q_val;
    logic                q_neg;
    logic signed [31:0]  z_new;

    // Truncated fixed-point product, saturated to 32 bits.
    assign fm_sh = prod.mag >> FRAC_BITS;
    always_comb begin
        if (fm_sh > 63'(nccr_pkg::SAT_MAX)) begin
            fm = prod.neg ? nccr_pkg::SAT_MIN : nccr_pkg::SAT_MAX;
        end else begin
            fm = prod.neg ? -$signed(fm_sh[31:0]) : $signed(fm_sh[31:0]);
        end
    end

    assign ps    = prod.neg ? -$signed({2'b00, prod.mag}) : $signed({2'b00, prod.mag});
    assign sumsq = {1'b0, r_acc} + {2'b00, prod.mag};

    always_comb begin
        case (r_k)
            2'd0: begin
                root_r = ONE;
                root_i = '0;
            end
            2'd1: begin
                root_r = -HALF;
                root_i = S3;
            end
            default: begin
                root_r = -HALF;
                root_i = -S3;
            end
        endcase
    end

    assign dx = nccr_pkg::sat32(nccr_pkg::ext32(r_zr) - root_r);
    assign dy = nccr_pkg::sat32(nccr_pkg::ext32(r_zi) - root_i);

    always_comb begin
        case (r_state)
            S_M0: begin op_a = r_zr;  op_b = r_zr; end
            S_M1: begin op_a = r_zi;  op_b = r_zi; end
            S_M2: begin op_a = r_zr;  op_b = r_zi; end
            S_M3: begin op_a = r_z2r; op_b = r_zr; end
            S_M4: begin op_a = r_z2i; op_b = r_zi; end
            S_M5: begin op_a = r_z2r; op_b = r_zi; end
            S_M6: begin op_a = r_z2i; op_b = r_zr; end
            S_M7: begin op_a = r_wr;  op_b = r_wr; end
            S_M8: begin op_a = r_wi;  op_b = r_wi; end
            S_C0: begin op_a = dx;    op_b = dx;   end
            S_C1: begin op_a = dy;    op_b = dy;   end
            S_D0: begin op_a = r_dr;  op_b = r_dr; end
            S_D1: begin op_a = r_di;  op_b = r_di; end
            S_D2: begin op_a = r_wr;  op_b = r_dr; end
            S_D3: begin op_a = r_wi;  op_b = r_di; end
            S_D4: begin op_a = r_wi;  op_b = r_dr; end
            S_D5: begin op_a = r_wr;  op_b = r_di; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    nccr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (prod)
    );

    // The real quotient starts when the numerators are ready; the imaginary
    // one starts in the cycle the real one finishes.
    assign div_start = (r_state == S_D6) || (r_state == S_V0 && div.done);
    assign div_src   = (r_state == S_D6) ? r_nr : r_ni;
    assign div_num   = div_src[64] ? 64'(-div_src) : div_src[63:0];

    nccr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_res   (div)
    );

    assign q_neg = (r_state == S_V0) ? r_nr[64] : r_ni[64];
    assign q_mag = div.sat ? 32'(nccr_pkg::SAT_MAX) : {1'b0, div.q};
    assign q_val = q_neg ? -$signed({34'd0, q_mag}) : $signed({34'd0, q_mag});
    assign z_new = nccr_pkg::sat32(
        nccr_pkg::ext32((r_state == S_V0) ? r_zr : r_zi) - q_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= 25'd1678;
            r_max       <= 8'd64;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    nccr_pkg::CFG_TOLERANCE: r_tol <= i_cfg_data;
                    nccr_pkg::CFG_MAX_ITER:  r_max <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_zr    <= i_start_real;
                        r_zi    <= i_start_imag;
                        r_steps <= '0;
                        if (i_start_real == '0 && i_start_imag == '0) begin
                            r_cls   <= nccr_pkg::CLS_ORIGIN;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_M0;
                        end
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_t     <= fm;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_z2r   <= nccr_pkg::sat32(nccr_pkg::ext32(r_t) - nccr_pkg::ext32(fm));
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_z2i   <= nccr_pkg::sat32(nccr_pkg::ext32(fm) <<< 1);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_t     <= fm;
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_wr <= nccr_pkg::sat32(nccr_pkg::ext32(nccr_pkg::sat32(
                        nccr_pkg::ext32(r_t) - nccr_pkg::ext32(fm))) - ONE);
                    r_state <= S_M6;
                end
                S_M6: begin
                    r_t     <= fm;
                    r_state <= S_M7;
                end
                S_M7: begin
                    r_wi    <= nccr_pkg::sat32(nccr_pkg::ext32(r_t) + nccr_pkg::ext32(fm));
                    r_state <= S_M8;
                end
                S_M8: begin
                    r_acc   <= {1'b0, prod.mag};
                    r_state <= S_M9;
                end
                S_M9: begin
                    r_dr <= nccr_pkg::sat32(nccr_pkg::ext32(r_z2r) * 66'sd3);
                    r_di <= nccr_pkg::sat32(nccr_pkg::ext32(r_z2i) * 66'sd3);
                    r_k  <= 2'd0;
                    if (sumsq <= {15'd0, r_tol2}) begin
                        r_state <= S_C0;
                    end else if (r_steps >= r_max) begin
                        r_cls   <= nccr_pkg::CLS_NO_CONV;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_D0;
                    end
                end
                S_C0: r_state <= S_C1;
                S_C1: begin
                    r_acc   <= {1'b0, prod.mag};
                    r_state <= S_C2;
                end
                S_C2: begin
                    if (sumsq < {15'd0, r_tol2}) begin
                        r_cls   <= {1'b0, r_k};
                        r_state <= S_DONE;
                    end else if (r_k == 2'd2) begin
                        r_cls   <= nccr_pkg::CLS_NO_CONV;
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_C0;
                    end
                end
                S_D0: r_state <= S_D1;
                S_D1: begin
                    r_acc   <= {1'b0, prod.mag};
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_den <= sumsq[63:0];
                    if (sumsq == '0) begin
                        r_cls   <= nccr_pkg::CLS_NO_CONV;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_D3;
                    end
                end
                S_D3: begin
                    r_nacc  <= ps;
                    r_state <= S_D4;
                end
                S_D4: begin
                    r_nr    <= r_nacc + ps;
                    r_state <= S_D5;
                end
                S_D5: begin
                    r_nacc  <= ps;
                    r_state <= S_D6;
                end
                S_D6: begin
                    r_ni    <= r_nacc - ps;
                    r_state <= S_V0;
                end
                S_V0: begin
                    if (div.done) begin
                        r_zr    <= z_new;
                        r_state <= S_V1;
                    end
                end
                S_V1: begin
                    if (div.done) begin
                        r_zi    <= z_new;
                        r_steps <= r_steps + 8'd1;
                        r_state <= S_M0;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_class <= r_cls;
                        r_out_steps <= r_steps;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tol2 <= r_tol * r_tol;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_root_class  = r_out_class;
    assign o_steps_taken = r_out_steps;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

/* rtl/core/nccr_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered exact product of two signed 32-bit values, as sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module nccr_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output nccr_pkg::t_prod         o_prod
);

    logic [31:0]     a_mag;
    logic [31:0]     b_mag;
    logic [63:0]     full;
    nccr_pkg::t_prod r_prod;

    // The negation of the most negative value wraps to 2^31, which is correct.
    assign a_mag = i_a[31] ? (32'd0 - i_a) : i_a;
    assign b_mag = i_b[31] ? (32'd0 - i_b) : i_b;
    assign full  = a_mag * b_mag;

    always_ff @(posedge i_clk) begin
        r_prod.neg <= i_a[31] ^ i_b[31];
        r_prod.mag <= full[62:0];
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* rtl/core/nccr_div.sv */
// ----------------------------------------------------------------------------
// Shared fraction divider
// Restoring divider for floor(n * 2^FRAC_BITS / d), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nccr_div #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output nccr_pkg::t_div_res o_res
);

    localparam int QBITS = 31;

    logic [63:0]  num_hi;
    logic [63:0]  num_sh;
    logic [64:0]  trial;
    logic         fits;
    logic [63:0]  r_rem;
    logic [30:0]  r_nlo;
    logic [30:0]  r_q;
    logic         r_sat;
    logic         r_busy;
    logic         r_done;
    logic [4:0]   r_cnt;

    // The quotient overflows 31 bits exactly when the upper part of the
    // shifted numerator is already at least the divisor.
    assign num_hi = i_num >> (QBITS - FRAC_BITS);
    assign num_sh = i_num << FRAC_BITS;
    assign trial  = {r_rem, r_nlo[30]};
    assign fits   = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QBITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem <= num_hi;
            r_nlo <= num_sh[30:0];
            r_sat <= num_hi >= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? 64'(trial - {1'b0, i_den}) : trial[63:0];
            r_nlo <= {r_nlo[29:0], 1'b0};
            r_q   <= {r_q[29:0], fits};
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.q    = r_q;

endmodule

`default_nettype wire

/* rtl/core/nccr_checker.sv */
// ----------------------------------------------------------------------------
// Newton cubic root classifier port checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module nccr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_root_class,
    input wire logic [7:0] o_steps_taken
);

    // A result waiting under stall stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_root_class)
            && $stable(o_steps_taken))
        else $error("stalled result changed");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_root_class <= nccr_pkg::CLS_NO_CONV)
        else $error("root class out of range");

    // The origin is reported without any Newton step.
    a_origin_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_root_class == nccr_pkg::CLS_ORIGIN |-> o_steps_taken == 8'd0)
        else $error("origin item with nonzero step count");

    // Once an item is taken the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while an item is in progress");

endmodule

bind newton_cubic_root_classifier_core nccr_checker u_nccr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_root_class  (o_root_class),
    .o_steps_taken (o_steps_taken)
);

`default_nettype wire

/* bench/tb_newton_cubic_root_classifier_core.sv */
// ----------------------------------------------------------------------------
// Newton cubic root classifier core testbench
// Drives complex start points through the core across several tolerance and
// iteration-cap settings, with random gaps and a long receiver hold-off, and
// checks every root class and step count against a bit-true predictor or a directed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_newton_cubic_root_classifier_core;

    localparam int  FRAC_BITS   = 24;
    localparam int  N_RANDOM    = 1400;
    localparam longint CYCLE_LIMIT = 64'd60_000_000;

    typedef struct {
        logic signed [31:0]    re;
        logic signed [31:0]    im;
        logic                  known;
        nccr_pkg::t_root_class cls;
        logic [7:0]            steps;
    } t_dir_row;

    typedef struct {
        nccr_pkg::t_root_class cls;
        logic [7:0]            steps;
    } t_class_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_start_real;
    logic signed [31:0] i_start_imag;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_root_class;
    logic [7:0]         o_steps_taken;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [24:0]        i_cfg_data;

    // Predictor copy of the two registers.
    logic [24:0] tol_q;
    logic [7:0]  cap_q;

    t_class_result pending_q[$];
    int     mismatches;
    bit     failed;
    bit     hold_long;
    longint cycles;

    newton_cubic_root_classifier_core #(.FRAC_BITS(FRAC_BITS)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_start_real (i_start_real),
        .i_start_imag (i_start_imag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_root_class (o_root_class),
        .o_steps_taken(o_steps_taken),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint signed_cap(bit neg, logic [63:0] m);
        if (m > 64'd2147483647) return neg ? -64'sd2147483648 : 64'sd2147483647;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] absval(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [63:0] m;
        m = (absval(a) * absval(b)) >> FRAC_BITS;
        return signed_cap((a < 0) != (b < 0), m);
    endfunction

    function automatic logic [63:0] square(longint a);
        return absval(a) * absval(a);
    endfunction

    // Signed sum of two exact products held as sign and magnitude.
    function automatic void smag_sum(bit an, logic [63:0] am, bit bn, logic [63:0] bm,
                                     output bit rn, output logic [63:0] rm);
        if (an == bn) begin
            rn = an; rm = am + bm;
        end else if (am >= bm) begin
            rn = an; rm = am - bm;
        end else begin
            rn = bn; rm = bm - am;
        end
        if (rm == 0) rn = 0;
    endfunction

    function automatic logic [63:0] qdiv(logic [63:0] n, logic [63:0] d);
        logic [63:0] q, r;
        q = n / d;
        r = n % d;
        if (q > (64'd2147483647 >> FRAC_BITS)) return 64'd2147483647;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return q > 64'd2147483647 ? 64'd2147483647 : q;
    endfunction

    function automatic bit close_to(longint zr, longint zi, longint rr, longint ri,
                                    logic [63:0] tol2);
        return square(clamp32(zr - rr)) + square(clamp32(zi - ri)) < tol2;
    endfunction

    function automatic t_class_result classify_point(logic signed [31:0] sr,
                                                     logic signed [31:0] si);
        longint one, s3, zr, zi, z2r, z2i, wr, wi, dr, di;
        logic [63:0] tol2, den, nrm, nim, t1m, t2m, qr, qi;
        bit nrn, nin, t1n, t2n;
        t_class_result res;
        one = 64'sd1 << FRAC_BITS;
        s3 = (((longint'(nccr_pkg::SQRT3_HALF_Q30) * 2) >>> (30 - FRAC_BITS)) + 1) >>> 1;
        tol2 = 64'(tol_q) * 64'(tol_q);
        zr = sr;
        zi = si;
        res.cls = nccr_pkg::CLS_NO_CONV;
        res.steps = 8'd0;
        if (sr == 0 && si == 0) begin
            res.cls = nccr_pkg::CLS_ORIGIN;
            return res;
        end
        forever begin
            z2r = clamp32(qmul(zr, zr) - qmul(zi, zi));
            z2i = clamp32(2 * qmul(zr, zi));
            wr = clamp32(clamp32(qmul(z2r, zr) - qmul(z2i, zi)) - one);
            wi = clamp32(qmul(z2r, zi) + qmul(z2i, zr));
            if (square(wr) + square(wi) <= tol2) begin
                if (close_to(zr, zi, one, 0, tol2))
                    res.cls = nccr_pkg::CLS_ROOT_ONE;
                else if (close_to(zr, zi, -(one / 2), s3, tol2))
                    res.cls = nccr_pkg::CLS_UPPER;
                else if (close_to(zr, zi, -(one / 2), -s3, tol2))
                    res.cls = nccr_pkg::CLS_LOWER;
                else
                    res.cls = nccr_pkg::CLS_NO_CONV;
                return res;
            end
            if (res.steps >= cap_q) return res;
            dr = clamp32(3 * z2r);
            di = clamp32(3 * z2i);
            den = square(dr) + square(di);
            if (den == 0) return res;
            smag_sum((wr < 0) != (dr < 0), absval(wr) * absval(dr),
                     (wi < 0) != (di < 0), absval(wi) * absval(di), nrn, nrm);
            t1n = (wi < 0) != (dr < 0);
            t1m = absval(wi) * absval(dr);
            t2n = !((wr < 0) != (di < 0));
            t2m = absval(wr) * absval(di);
            smag_sum(t1n, t1m, t2n, t2m, nin, nim);
            qr = qdiv(nrm, den);
            qi = qdiv(nim, den);
            zr = clamp32(zr - signed_cap(nrn, qr));
            zi = clamp32(zi - signed_cap(nin, qi));
            res.steps++;
        end
    endfunction

    // ---------------- driving ----------------
    task automatic write_reg(logic [0:0] idx, logic [24:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == nccr_pkg::CFG_TOLERANCE) tol_q = val;
        else cap_q = val[7:0];
        @(posedge i_clk);
    endtask

    // Gap lengths: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 94) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Valid stays high after an item is taken; the next call either offers
    // a new item right away or drops valid for the gap.
    task automatic send_point(logic signed [31:0] re, logic signed [31:0] im);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_real <= re;
        i_start_imag <= im;
        pending_q.push_back(classify_point(re, im));
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        // The block has gone idle by the time its last result leaves.
        repeat (40) @(posedge i_clk);
    endtask

    // Start point: mostly near the roots' basin scale, some full-range.
    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $signed($urandom_range(0, 32'h0600_0000)) - 32'sh0300_0000;
        if (r < 8) return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        return $urandom();
    endfunction

    // ---------------- receiver and checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                failed <= 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: class %0d steps %0d",
                             o_root_class, o_steps_taken);
            end else begin
                t_class_result e;
                e = pending_q.pop_front();
                if (o_root_class !== e.cls || o_steps_taken !== e.steps) begin
                    failed <= 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected class %0d steps %0d, got %0d %0d",
                                 e.cls, e.steps, o_root_class, o_steps_taken);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_long) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(0, 99) < 25) ||
                            ($urandom_range(0, 199) == 0);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    t_dir_row dir_rows[$];

    initial begin
        logic [24:0] tols[4];
        logic [7:0]  caps[4];
        logic signed [31:0] one;
        one = 32'sd1 <<< FRAC_BITS;
        mismatches = 0;
        failed = 0;
        hold_long = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_start_real = '0;
        i_start_imag = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = nccr_pkg::CFG_TOLERANCE;
        i_cfg_data = '0;
        tol_q = 25'd1678;
        cap_q = 8'd64;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset settings.
        dir_rows = '{
            '{32'sd0, 32'sd0, 1'b1, nccr_pkg::CLS_ORIGIN, 8'd0},
            '{one, 32'sd0, 1'b1, nccr_pkg::CLS_ROOT_ONE, 8'd0},
            '{32'sh7fffffff, 32'sh7fffffff, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{32'sh80000000, 32'sh80000000, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{32'sh80000000, 32'sh7fffffff, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{32'sd1, 32'sd0, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{32'sd0, -32'sd1, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{-(one / 2), 32'sd14529495, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{-(one / 2), -32'sd14529495, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{2 * one, one, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{-one, 32'sd0, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0},
            '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, nccr_pkg::CLS_NO_CONV, 8'd0}
        };
        foreach (dir_rows[k]) begin
            send_point(dir_rows[k].re, dir_rows[k].im);
            if (dir_rows[k].known) begin
                pending_q[pending_q.size() - 1].cls   = dir_rows[k].cls;
                pending_q[pending_q.size() - 1].steps = dir_rows[k].steps;
            end
        end
        drain();

        // Smallest settings: cap of one step, zero-like tolerance.
        write_reg(nccr_pkg::CFG_MAX_ITER, 25'd1);
        write_reg(nccr_pkg::CFG_TOLERANCE, 25'd1);
        send_point(2 * one, 32'sd0);
        pending_q[pending_q.size() - 1].cls   = nccr_pkg::CLS_NO_CONV;
        pending_q[pending_q.size() - 1].steps = 8'd1;
        send_point(32'sd0, 32'sd0);
        pending_q[pending_q.size() - 1].cls   = nccr_pkg::CLS_ORIGIN;
        pending_q[pending_q.size() - 1].steps = 8'd0;
        send_point(one, 32'sd0);
        drain();

        tols = '{25'd1678, 25'd1, 25'd16777216, 25'd200000};
        caps = '{8'd64, 8'd1, 8'd255, 8'd12};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(nccr_pkg::CFG_TOLERANCE, tols[ph]);
            write_reg(nccr_pkg::CFG_MAX_ITER,
                      ph == 2 ? 25'(caps[ph]) : 25'($urandom_range(1, 40)));
            if (ph == 0) write_reg(nccr_pkg::CFG_MAX_ITER, 25'(caps[0]));
            if (ph == 1) begin
                // Receiver holds off while the sender keeps offering items.
                fork
                    begin
                        hold_long = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_long = 0;
                    end
                join_none
            end
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                // Large start points take many steps; keep them rare at cap 255.
                if (ph == 2 && $urandom_range(0, 3) != 0)
                    send_point($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000,
                               $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
                else if ($urandom_range(0, 49) == 0)
                    send_point(32'sd0, 32'sd0);
                else
                    send_point(rand_coord(), rand_coord());
            end
            drain();
        end

        if (!failed && pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
